@@ hw/rtl/max_min_heap_engine_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the max-min heap engine
// ---------------------------------------------------------------------------
`ifndef MAX_MIN_HEAP_ENGINE_CORE_ASSERT_SVH
`define MAX_MIN_HEAP_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge, held off during reset
`define MMH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heap engine assertion failed");
// Condition that must hold on every clock edge, held off during reset
`define MMH_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("heap engine invariant violated");
`else
`define MMH_ASSERT(label, prop)
`define MMH_ASSERT_ALWAYS(label, cond)
`endif
`endif

@@ hw/rtl/mmh_pkg.sv @@
// ---------------------------------------------------------------------------
// mmh_pkg
// Shared types, sizes, codes and compare helpers for the max-min heap engine.
// ---------------------------------------------------------------------------
package mmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW       = $clog2(CAPACITY);  // heap index width
    localparam int CW       = AW + 1;            // count width, holds CAPACITY
    localparam int WW       = AW + 3;            // grandchild address width
    localparam int KW       = 32;

    typedef logic signed [KW-1:0] key_t;
    typedef logic [AW-1:0]        idx_t;
    typedef logic [CW-1:0]        cnt_t;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMIN = 2'd1;
    localparam logic [1:0] CMD_DELMAX = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_UP0, S_UP1, S_CL0, S_CL1,
        S_DR1, S_DR2, S_DK, S_DRK, S_DRL, S_DL,
        S_TST, S_SCAN, S_DEC, S_W2, S_WL,
        S_FIN, S_FA, S_FB, S_FC, S_OUT
    } state_t;

    // dir high: larger key wins (max level), low: smaller key wins
    function automatic logic better(key_t a, key_t b, logic dir);
        better = dir ? (a > b) : (a < b);
    endfunction

    // depth of index i is the msb position of i+1; even depth is a max level
    function automatic logic on_max_level(cnt_t i);
        logic [CW:0] t;
        logic        par;
        t   = {1'b0, i} + {{CW{1'b0}}, 1'b1};
        par = 1'b0;
        for (int b = 0; b <= CW; b++)
        begin
            if (t[b])
            begin
                par = b[0];
            end
        end
        on_max_level = !par;
    endfunction

endpackage

@@ hw/rtl/max_min_heap_engine_core.sv @@
// ---------------------------------------------------------------------------
// max_min_heap_engine_core
// Double-ended priority queue of signed 32-bit keys held in a max-min heap.
// ---------------------------------------------------------------------------
// One command word is taken at a time. Insert, delete min and delete max each
// return the removed key, the new min and max, the count and a status. All keys
// live in a RAM with one read port and registered read data; a sequencer moves
// one key through the heap. An insert climbs by grandparent levels; a delete
// walks down by double levels (a leaf test, up to six child and grandchild
// reads pipelined one per cycle, then a decision and a parent fix). Both end
// by reading back the root and its children for min and max and by loading
// the output register.
// A new word is taken while the previous result still waits at the output.
// ---------------------------------------------------------------------------
`include "max_min_heap_engine_core_assert.svh"

module max_min_heap_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] removed_value,
    output logic signed [31:0] min_value,
    output logic signed [31:0] max_value,
    output logic [10:0]        count,
    output logic [1:0]         status
);

    localparam int AW = mmh_pkg::AW;
    localparam int CW = mmh_pkg::CW;
    localparam int WW = mmh_pkg::WW;

    mmh_pkg::state_t state_reg, state_next;
    mmh_pkg::idx_t   i_reg, i_next;
    mmh_pkg::key_t   x_reg, x_next;
    mmh_pkg::cnt_t   cnt_reg, cnt_next;
    logic            dir_reg, dir_next;
    logic [2:0]      step_reg, step_next;
    logic            pend_reg, pend_next;
    logic [2:0]      pstep_reg, pstep_next;
    mmh_pkg::idx_t   paddr_reg, paddr_next;
    mmh_pkg::key_t   bv_reg, bv_next;
    mmh_pkg::idx_t   bm_reg, bm_next;
    logic [2:0]      bs_reg, bs_next;
    mmh_pkg::key_t   c0_reg, c0_next;
    mmh_pkg::key_t   c1_reg, c1_next;
    mmh_pkg::key_t   t1_reg, t1_next;
    mmh_pkg::key_t   rem_reg, rem_next;
    logic [1:0]      st_reg, st_next;
    mmh_pkg::key_t   mn_reg, mn_next;
    mmh_pkg::key_t   mx_reg, mx_next;

    logic            out_valid_reg, out_valid_next;
    mmh_pkg::key_t   o_rem_reg, o_rem_next;
    mmh_pkg::key_t   o_mn_reg, o_mn_next;
    mmh_pkg::key_t   o_mx_reg, o_mx_next;
    mmh_pkg::cnt_t   o_cnt_reg, o_cnt_next;
    logic [1:0]      o_st_reg, o_st_next;

    logic            ram_we;
    mmh_pkg::idx_t   ram_waddr, ram_raddr;
    mmh_pkg::key_t   ram_wdata, ram_rdata;

    logic            accept;

    mmh_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall      = (state_reg != mmh_pkg::S_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign removed_value = o_rem_reg;
    assign min_value     = o_mn_reg;
    assign max_value     = o_mx_reg;
    assign count         = o_cnt_reg;
    assign status        = o_st_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmh_pkg::S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        x_reg     <= x_next;
        dir_reg   <= dir_next;
        step_reg  <= step_next;
        pstep_reg <= pstep_next;
        paddr_reg <= paddr_next;
        bv_reg    <= bv_next;
        bm_reg    <= bm_next;
        bs_reg    <= bs_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        t1_reg    <= t1_next;
        rem_reg   <= rem_next;
        st_reg    <= st_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        o_rem_reg <= o_rem_next;
        o_mn_reg  <= o_mn_next;
        o_mx_reg  <= o_mx_next;
        o_cnt_reg <= o_cnt_next;
        o_st_reg  <= o_st_next;
    end

    // sequencer
    always_comb
    begin
        logic [WW-1:0] wi;
        logic [WW-1:0] saddr;
        logic [WW-1:0] wn;
        logic          issue;
        mmh_pkg::idx_t last;
        mmh_pkg::idx_t par;
        mmh_pkg::idx_t gpar;
        mmh_pkg::key_t cp;
        mmh_pkg::idx_t pidx;

        wi    = {3'b000, i_reg};
        wn    = {{(WW-CW){1'b0}}, cnt_reg};
        last  = AW'(cnt_reg - 1'b1);
        par   = (i_reg - 1'b1) >> 1;
        gpar  = (i_reg - AW'(3)) >> 2;
        cp    = bs_reg[2] ? c1_reg : c0_reg;
        pidx  = AW'({i_reg, 1'b1} + {{AW{1'b0}}, bs_reg[2]});
        case (step_reg)
            3'd0:    saddr = (wi << 1) + WW'(1);
            3'd1:    saddr = (wi << 1) + WW'(2);
            default: saddr = (wi << 2) + WW'(3) + WW'(step_reg - 3'd2);
        endcase
        issue = (step_reg < 3'd6) && (saddr < wn);

        state_next     = state_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        step_next      = step_reg;
        pend_next      = 1'b0;
        pstep_next     = pstep_reg;
        paddr_next     = paddr_reg;
        bv_next        = bv_reg;
        bm_next        = bm_reg;
        bs_next        = bs_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        t1_next        = t1_reg;
        rem_next       = rem_reg;
        st_next        = st_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_rem_next     = o_rem_reg;
        o_mn_next      = o_mn_reg;
        o_mx_next      = o_mx_reg;
        o_cnt_next     = o_cnt_reg;
        o_st_next      = o_st_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_reg;
        ram_wdata      = x_reg;
        ram_raddr      = i_reg;

        case (state_reg)
            // take a word and pick the command path
            mmh_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = '0;
                    st_next    = mmh_pkg::ST_DONE;
                    state_next = mmh_pkg::S_FIN;
                    if (cmd == mmh_pkg::CMD_INSERT)
                    begin
                        if (cnt_reg >= CW'(mmh_pkg::CAPACITY))
                        begin
                            st_next = mmh_pkg::ST_FULL;
                        end
                        else
                        begin
                            i_next     = AW'(cnt_reg);
                            x_next     = value;
                            dir_next   = mmh_pkg::on_max_level(cnt_reg);
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = mmh_pkg::S_UP0;
                        end
                    end
                    else if (cmd == mmh_pkg::CMD_DELMIN || cmd == mmh_pkg::CMD_DELMAX)
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = mmh_pkg::ST_EMPTY;
                        end
                        else if (cmd == mmh_pkg::CMD_DELMAX || cnt_reg == CW'(1))
                        begin
                            i_next     = '0;
                            state_next = mmh_pkg::S_DRK;
                        end
                        else if (cnt_reg == CW'(2))
                        begin
                            i_next     = AW'(1);
                            state_next = mmh_pkg::S_DRK;
                        end
                        else
                        begin
                            state_next = mmh_pkg::S_DR1;
                        end
                    end
                end
            end
            // insert: compare with parent
            mmh_pkg::S_UP0:
            begin
                if (i_reg != '0)
                begin
                    ram_raddr  = par;
                    state_next = mmh_pkg::S_UP1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = mmh_pkg::S_FIN;
                end
            end
            mmh_pkg::S_UP1:
            begin
                if (mmh_pkg::better(ram_rdata, x_reg, dir_reg))
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    i_next    = par;
                    dir_next  = !dir_reg;
                end
                state_next = mmh_pkg::S_CL0;
            end
            // insert: climb by grandparents
            mmh_pkg::S_CL0:
            begin
                if (i_reg >= AW'(3))
                begin
                    ram_raddr  = gpar;
                    state_next = mmh_pkg::S_CL1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = mmh_pkg::S_FIN;
                end
            end
            mmh_pkg::S_CL1:
            begin
                ram_we = 1'b1;
                if (mmh_pkg::better(x_reg, ram_rdata, dir_reg))
                begin
                    ram_wdata  = ram_rdata;
                    i_next     = gpar;
                    state_next = mmh_pkg::S_CL0;
                end
                else
                begin
                    state_next = mmh_pkg::S_FIN;
                end
            end
            // delete min: compare the two root children
            mmh_pkg::S_DR1:
            begin
                ram_raddr  = AW'(1);
                state_next = mmh_pkg::S_DR2;
            end
            mmh_pkg::S_DR2:
            begin
                t1_next    = ram_rdata;
                ram_raddr  = AW'(2);
                state_next = mmh_pkg::S_DK;
            end
            mmh_pkg::S_DK:
            begin
                if (t1_reg < ram_rdata)
                begin
                    i_next   = AW'(1);
                    rem_next = t1_reg;
                end
                else
                begin
                    i_next   = AW'(2);
                    rem_next = ram_rdata;
                end
                ram_raddr  = last;
                state_next = mmh_pkg::S_DL;
            end
            // delete: fetch the removed key, then the last key
            mmh_pkg::S_DRK:
            begin
                state_next = mmh_pkg::S_DRL;
            end
            mmh_pkg::S_DRL:
            begin
                rem_next   = ram_rdata;
                ram_raddr  = last;
                state_next = mmh_pkg::S_DL;
            end
            mmh_pkg::S_DL:
            begin
                x_next     = ram_rdata;
                cnt_next   = cnt_reg - 1'b1;
                dir_next   = (i_reg == '0);
                state_next = mmh_pkg::S_TST;
            end
            // trickle: stop at a leaf
            mmh_pkg::S_TST:
            begin
                step_next = '0;
                if (((wi << 1) + WW'(1)) >= wn)
                begin
                    ram_we     = 1'b1;
                    state_next = mmh_pkg::S_FIN;
                end
                else
                begin
                    state_next = mmh_pkg::S_SCAN;
                end
            end
            // trickle: stream children and grandchildren, keep the best
            mmh_pkg::S_SCAN:
            begin
                ram_raddr = saddr[AW-1:0];
                if (issue)
                begin
                    pend_next  = 1'b1;
                    pstep_next = step_reg;
                    paddr_next = saddr[AW-1:0];
                    step_next  = step_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (pstep_reg == 3'd0)
                    begin
                        c0_next = ram_rdata;
                    end
                    if (pstep_reg == 3'd1)
                    begin
                        c1_next = ram_rdata;
                    end
                    if (pstep_reg == 3'd0 || mmh_pkg::better(ram_rdata, bv_reg, dir_reg))
                    begin
                        bv_next = ram_rdata;
                        bm_next = paddr_reg;
                        bs_next = pstep_reg;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = mmh_pkg::S_DEC;
                end
            end
            mmh_pkg::S_DEC:
            begin
                ram_we = 1'b1;
                if (mmh_pkg::better(bv_reg, x_reg, dir_reg))
                begin
                    ram_wdata  = bv_reg;
                    state_next = (bs_reg >= 3'd2) ? mmh_pkg::S_W2 : mmh_pkg::S_WL;
                end
                else
                begin
                    state_next = mmh_pkg::S_FIN;
                end
            end
            // grandchild moved up: fix against its parent, descend
            mmh_pkg::S_W2:
            begin
                if (mmh_pkg::better(cp, x_reg, dir_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx;
                    x_next    = cp;
                end
                i_next     = bm_reg;
                state_next = mmh_pkg::S_TST;
            end
            // child moved up: the key lands in its place
            mmh_pkg::S_WL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = bm_reg;
                state_next = mmh_pkg::S_FIN;
            end
            // read back root and children for min and max
            mmh_pkg::S_FIN:
            begin
                mn_next   = '0;
                mx_next   = '0;
                ram_raddr = '0;
                state_next = (cnt_reg == '0) ? mmh_pkg::S_OUT : mmh_pkg::S_FA;
            end
            mmh_pkg::S_FA:
            begin
                mx_next    = ram_rdata;
                ram_raddr  = AW'(1);
                state_next = mmh_pkg::S_FB;
            end
            mmh_pkg::S_FB:
            begin
                ram_raddr = AW'(2);
                if (cnt_reg == CW'(1))
                begin
                    mn_next    = mx_reg;
                    state_next = mmh_pkg::S_OUT;
                end
                else if (cnt_reg == CW'(2))
                begin
                    mn_next    = ram_rdata;
                    state_next = mmh_pkg::S_OUT;
                end
                else
                begin
                    t1_next    = ram_rdata;
                    state_next = mmh_pkg::S_FC;
                end
            end
            mmh_pkg::S_FC:
            begin
                mn_next    = (t1_reg < ram_rdata) ? t1_reg : ram_rdata;
                state_next = mmh_pkg::S_OUT;
            end
            // hand the result to the output register
            mmh_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_rem_next     = rem_reg;
                    o_mn_next      = mn_reg;
                    o_mx_next      = mx_reg;
                    o_cnt_next     = cnt_reg;
                    o_st_next      = st_reg;
                    state_next     = mmh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mmh_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `MMH_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(mmh_pkg::CAPACITY))
    `MMH_ASSERT(a_word_leaves_idle, accept |=> (state_reg != mmh_pkg::S_IDLE))
    `MMH_ASSERT(a_result_from_out, $rose(out_valid_reg) |-> ($past(state_reg) == mmh_pkg::S_OUT))

endmodule

@@ hw/rtl/mmh_ram.sv @@
// ---------------------------------------------------------------------------
// mmh_ram
// Heap key store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mmh_ram (
    input  logic          clk,
    input  logic          we,
    input  mmh_pkg::idx_t waddr,
    input  mmh_pkg::key_t wdata,
    input  mmh_pkg::idx_t raddr,
    output mmh_pkg::key_t rdata
);

    mmh_pkg::key_t mem [mmh_pkg::CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
